@@ rtl/core/dcsms_pkg.sv @@
package dcsms_pkg;

   // Sizing of the chain and of one frame
   localparam int MAX_CHIPS_DEF  = 8;
   localparam int FRAME_LIMIT    = 8;
   localparam int CNT_W          = 4;   // chip_count register width
   localparam int LIMIT_W        = 7;   // channel_limit register width
   localparam int K_W            = 3;   // byte counter inside one frame
   localparam int ADDR_W         = 5;   // chip index taken from an 8-bit channel
   localparam int PADDR_W        = 4;
   localparam int PDATA_W        = 32;

   localparam logic [7:0] MASK_NONE = 8'h00;

   // Register reset values
   localparam logic [CNT_W-1:0]   CHIP_COUNT_RST    = 4'd1;
   localparam logic [LIMIT_W-1:0] CHANNEL_LIMIT_RST = 7'd64;

   // Register indexes, paddr[3:2]
   typedef enum logic [1:0] {
      REG_CHIP_COUNT     = 2'd0,
      REG_CHANNEL_LIMIT  = 2'd1,
      REG_BYTE_ZERO_MODE = 2'd2
   } reg_index_type;

   // Command codes
   typedef enum logic [1:0] {
      CMD_EXCL_ON = 2'd0,
      CMD_ADD_ON  = 2'd1,
      CMD_OFF     = 2'd2,
      CMD_ALL_OFF = 2'd3
   } cmd_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EDIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] channel;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic       status;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]   chip_count;
      logic [LIMIT_W-1:0] channel_limit;
      logic               byte_zero_mode;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic latch;
      logic edit;
      logic load;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_free;
      logic last_load;
   } ctl_status_type;

endpackage

@@ rtl/core/dcsms_csr.sv @@
module dcsms_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dcsms_pkg::PADDR_W-1:0]     paddr,
   input  logic [dcsms_pkg::PDATA_W-1:0]     pwdata,
   output logic [dcsms_pkg::PDATA_W-1:0]     prdata,
   output logic                              pready,
   output dcsms_pkg::cfg_type                cfg
);

   dcsms_pkg::cfg_type cfg_ff, cfg_in;
   logic               wr_en;
   logic [1:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   // Write the addressed register; other addresses are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            dcsms_pkg::REG_CHIP_COUNT:
               cfg_in.chip_count = pwdata[dcsms_pkg::CNT_W-1:0];
            dcsms_pkg::REG_CHANNEL_LIMIT:
               cfg_in.channel_limit = pwdata[dcsms_pkg::LIMIT_W-1:0];
            dcsms_pkg::REG_BYTE_ZERO_MODE:
               cfg_in.byte_zero_mode = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chip_count     <= dcsms_pkg::CHIP_COUNT_RST;
         cfg_ff.channel_limit  <= dcsms_pkg::CHANNEL_LIMIT_RST;
         cfg_ff.byte_zero_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_idx)
         dcsms_pkg::REG_CHIP_COUNT:
            prdata = dcsms_pkg::PDATA_W'(cfg_ff.chip_count);
         dcsms_pkg::REG_CHANNEL_LIMIT:
            prdata = dcsms_pkg::PDATA_W'(cfg_ff.channel_limit);
         dcsms_pkg::REG_BYTE_ZERO_MODE:
            prdata = dcsms_pkg::PDATA_W'(cfg_ff.byte_zero_mode);
         default:
            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/dcsms_ctrl.sv @@
module dcsms_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  dcsms_pkg::ctl_status_type  status,
   output dcsms_pkg::ctl_cmd_type     cmd
);

   dcsms_pkg::state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dcsms_pkg::ST_IDLE: begin
            if (req_valid) state_in = dcsms_pkg::ST_EDIT;
         end
         dcsms_pkg::ST_EDIT: begin
            state_in = dcsms_pkg::ST_EMIT;
         end
         dcsms_pkg::ST_EMIT: begin
            if (status.slot_free && status.last_load) state_in = dcsms_pkg::ST_IDLE;
         end
         default: state_in = dcsms_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcsms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         dcsms_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         dcsms_pkg::ST_EDIT: begin
            cmd.edit = 1'b1;
         end
         dcsms_pkg::ST_EMIT: begin
            cmd.load = status.slot_free;
         end
         default: ;
      endcase
   end

endmodule

@@ rtl/core/dcsms_dp.sv @@
module dcsms_dp #(
   parameter int MAX_CHIPS = dcsms_pkg::MAX_CHIPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dcsms_pkg::req_type         req_data,
   input  dcsms_pkg::cfg_type         cfg,
   input  dcsms_pkg::ctl_cmd_type     cmd,
   output dcsms_pkg::ctl_status_type  status,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output dcsms_pkg::rsp_type         rsp_data
);

   localparam int IDX_W     = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
   localparam int FRAME_CAP = (MAX_CHIPS < dcsms_pkg::FRAME_LIMIT) ?
                              MAX_CHIPS : dcsms_pkg::FRAME_LIMIT;

   logic [7:0]                    mask_ff [MAX_CHIPS];
   logic [7:0]                    mask_in [MAX_CHIPS];
   logic [1:0]                    cmd_ff;
   logic [7:0]                    chan_ff;
   logic                          err_ff, err_in;
   logic [dcsms_pkg::K_W-1:0]     k_ff, k_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   dcsms_pkg::rsp_type            rsp_ff, rsp_in;

   logic [dcsms_pkg::CNT_W-1:0]   cnt_nz;
   logic [dcsms_pkg::CNT_W-1:0]   n_eff;
   logic [7:0]                    ch_m1;
   logic [dcsms_pkg::ADDR_W-1:0]  chip;
   logic [7:0]                    bit_n;
   logic [7:0]                    bit_z;
   logic                          over_limit;
   logic                          chip_bad;
   logic [dcsms_pkg::ADDR_W-1:0]  emit_addr;
   logic [dcsms_pkg::ADDR_W-1:0]  rd_addr;
   logic [7:0]                    rd_data;
   logic                          last_k;
   logic                          edit_err;
   logic                          clear_n;
   logic                          wr_one;
   logic [7:0]                    wr_data;

   // Effective chip count: zero reads as one, saturate at the frame cap
   assign cnt_nz = (cfg.chip_count == '0) ? dcsms_pkg::CNT_W'(1) : cfg.chip_count;
   assign n_eff  = (cnt_nz > dcsms_pkg::CNT_W'(FRAME_CAP)) ?
                   dcsms_pkg::CNT_W'(FRAME_CAP) : cnt_nz;

   // Decode the channel into chip and bit
   assign ch_m1      = chan_ff - 8'd1;
   assign chip       = ch_m1[7:3];
   assign bit_n      = 8'b1 << ch_m1[2:0];
   assign bit_z      = ((chan_ff != 8'd0) && (chan_ff <= 8'd8)) ? bit_n : dcsms_pkg::MASK_NONE;
   assign over_limit = chan_ff > {1'b0, cfg.channel_limit};
   assign chip_bad   = chip >= dcsms_pkg::ADDR_W'(n_eff);

   // Single read port: edit target during edit, frame byte otherwise
   assign emit_addr = dcsms_pkg::ADDR_W'(n_eff - dcsms_pkg::CNT_W'(1) - {1'b0, k_ff});
   assign rd_addr   = cmd.edit ? (cfg.byte_zero_mode ? '0 : chip) : emit_addr;
   assign rd_data   = mask_ff[rd_addr[IDX_W-1:0]];
   assign last_k    = ({1'b0, k_ff} == (n_eff - dcsms_pkg::CNT_W'(1)));

   // Decide the edit for the held command
   always_comb begin
      edit_err = 1'b0;
      clear_n  = 1'b0;
      wr_one   = 1'b0;
      wr_data  = rd_data;
      if (cmd_ff == dcsms_pkg::CMD_ALL_OFF) begin
         clear_n = 1'b1;
      end else if (over_limit || (cmd_ff == dcsms_pkg::CMD_OFF && chan_ff == 8'd0)) begin
         edit_err = 1'b1;
      end else if (cfg.byte_zero_mode) begin
         wr_one = 1'b1;
         priority if (cmd_ff == dcsms_pkg::CMD_EXCL_ON) begin
            wr_data = bit_z;
         end else if (cmd_ff == dcsms_pkg::CMD_ADD_ON) begin
            wr_data = (chan_ff == 8'd0) ? dcsms_pkg::MASK_NONE : (rd_data | bit_z);
         end else begin
            wr_data = rd_data & ~bit_z;
         end
      end else if (chan_ff == 8'd0) begin
         clear_n = (cmd_ff == dcsms_pkg::CMD_EXCL_ON);
      end else if (chip_bad) begin
         edit_err = 1'b1;
      end else begin
         wr_one = 1'b1;
         priority if (cmd_ff == dcsms_pkg::CMD_EXCL_ON) begin
            clear_n = 1'b1;
            wr_data = bit_n;
         end else if (cmd_ff == dcsms_pkg::CMD_ADD_ON) begin
            wr_data = rd_data | bit_n;
         end else begin
            wr_data = rd_data & ~bit_n;
         end
      end
   end

   // Apply clears first, then the single-entry write
   always_comb begin
      for (int i = 0; i < MAX_CHIPS; i++) begin
         mask_in[i] = mask_ff[i];
         if (cmd.edit && clear_n &&
             (dcsms_pkg::ADDR_W'(i) < dcsms_pkg::ADDR_W'(n_eff))) begin
            mask_in[i] = dcsms_pkg::MASK_NONE;
         end
         if (cmd.edit && wr_one && (dcsms_pkg::ADDR_W'(i) == rd_addr)) begin
            mask_in[i] = wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHIPS; i++) mask_ff[i] <= dcsms_pkg::MASK_NONE;
      end else begin
         for (int i = 0; i < MAX_CHIPS; i++) mask_ff[i] <= mask_in[i];
      end
   end

   // Hold the accepted command word
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff  <= req_data.cmd;
         chan_ff <= req_data.channel;
      end
   end

   // Error flag and frame byte counter
   always_comb begin
      err_in = err_ff;
      k_in   = k_ff;
      if (cmd.edit) begin
         err_in = edit_err;
         k_in   = '0;
      end else if (cmd.load) begin
         k_in = k_ff + dcsms_pkg::K_W'(1);
      end
   end

   // Output register: load a byte, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         if (err_ff) begin
            rsp_in.frame_byte = dcsms_pkg::MASK_NONE;
            rsp_in.last_byte  = 1'b1;
            rsp_in.status     = 1'b1;
         end else begin
            rsp_in.frame_byte = rd_data;
            rsp_in.last_byte  = last_k;
            rsp_in.status     = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff       <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         err_ff       <= err_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign status.slot_free = !rsp_valid_ff || rsp_ready;
   assign status.last_load = err_ff || last_k;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

   // An error load always yields a terminal error word
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      cmd.load && err_ff |=> rsp_valid_ff && rsp_ff.status && rsp_ff.last_byte &&
                             (rsp_ff.frame_byte == dcsms_pkg::MASK_NONE))
      else $error("error load did not produce error word");

   // A word with an error status is always the final word
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status |-> rsp_ff.last_byte)
      else $error("error word not flagged last");

   // A pending non-final byte means the counter is still inside the frame
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last_byte |-> ({1'b0, k_ff} < n_eff))
      else $error("frame counter ran past chip count");

endmodule

@@ rtl/core/daisy_chain_switch_mask_shifter.sv @@
// Keeps one 8-bit switch mask per chip of a daisy chain of octal switches and,
// for each accepted command word, edits the masks and sends the whole frame as
// one response word per chip, last chip first, with last_byte on the final one.
// A rejected command (channel above channel_limit, channel past the chip count
// outside byte-zero mode, or turn-off of channel 0) returns a single error
// word and leaves the masks alone. Commands are handled one at a time by a
// small controller: it takes the word, applies the edit through the single
// mask read port, then loads one frame byte per cycle while the response side
// does not stall, n bytes (n = effective chip count, 1 to 8) or one error word.
// The response register lets the next command be taken while the final byte
// still waits. Masks clear at reset; configure only while no command is in
// flight.
module daisy_chain_switch_mask_shifter #(
   parameter int MAX_CHIPS = dcsms_pkg::MAX_CHIPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  dcsms_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dcsms_pkg::rsp_type             rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dcsms_pkg::PADDR_W-1:0]  paddr,
   input  logic [dcsms_pkg::PDATA_W-1:0]  pwdata,
   output logic [dcsms_pkg::PDATA_W-1:0]  prdata,
   output logic                           pready
);

   dcsms_pkg::cfg_type         cfg;
   dcsms_pkg::ctl_cmd_type     ctl_cmd;
   dcsms_pkg::ctl_status_type  ctl_status;

   dcsms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dcsms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (ctl_status),
      .cmd       (ctl_cmd)
   );

   dcsms_dp #(
      .MAX_CHIPS (MAX_CHIPS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (ctl_cmd),
      .status    (ctl_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sim/tb_daisy_chain_switch_mask_shifter.sv @@
`timescale 1ns / 1ps

module tb_daisy_chain_switch_mask_shifter;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int RANDOM_PHASES   = 7;
   localparam int WORDS_PER_PHASE = 43;
   localparam int CHANS_PER_CHIP  = 8;
   localparam int RESET_CYCLES    = 9;

   // One line of the directed stimulus: a register write or a command word
   typedef struct packed {
      bit                       is_cfg;
      dcsms_pkg::reg_index_type idx;
      logic [31:0]              value;
      dcsms_pkg::req_type       word;
      bit                       typed;
      dcsms_pkg::rsp_type       want;
   } dir_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   dcsms_pkg::req_type             req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   dcsms_pkg::rsp_type             rsp_data;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [dcsms_pkg::PADDR_W-1:0]  paddr;
   logic [dcsms_pkg::PDATA_W-1:0]  pwdata;
   logic [dcsms_pkg::PDATA_W-1:0]  prdata;
   logic                           pready;

   // Predicted switch masks and register copies
   logic [7:0]                     sw_mask [0:dcsms_pkg::MAX_CHIPS_DEF-1];
   logic [dcsms_pkg::CNT_W-1:0]    cfg_chips;
   logic [dcsms_pkg::LIMIT_W-1:0]  cfg_limit;
   logic                           cfg_bzm;

   dcsms_pkg::rsp_type             frame_buf[$];
   dcsms_pkg::rsp_type             owed_bytes[$];
   dcsms_pkg::rsp_type             due_word;

   int                  fail_count    = 0;
   int                  cmd_count     = 0;
   int                  reject_count  = 0;
   int                  byte_count    = 0;
   int                  setting_count = 0;
   int                  cycle_count   = 0;
   bit                  no_idle       = 1'b0;

   daisy_chain_switch_mask_shifter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Clamp the chip count the way the frame length is derived
   function automatic int chips_in_use();
      int n;
      n = cfg_chips;
      if (n == 0) n = 1;
      if (n > dcsms_pkg::MAX_CHIPS_DEF) n = dcsms_pkg::MAX_CHIPS_DEF;
      if (n > dcsms_pkg::FRAME_LIMIT) n = dcsms_pkg::FRAME_LIMIT;
      return n;
   endfunction

   function automatic void clear_masks(int n);
      for (int i = 0; i < n; i++) sw_mask[i] = dcsms_pkg::MASK_NONE;
   endfunction

   // Apply one command to the predicted masks; return 0 if it is rejected
   function automatic bit edit_masks(dcsms_pkg::req_type r, int n);
      dcsms_pkg::cmd_code_type op;
      int                      ch;
      int                      chip;
      logic [7:0]              sel;
      op = dcsms_pkg::cmd_code_type'(r.cmd);
      ch = r.channel;
      // All-off ignores the channel and cannot fail
      if (op == dcsms_pkg::CMD_ALL_OFF) begin
         clear_masks(n);
         return 1'b1;
      end
      if (ch > cfg_limit) return 1'b0;
      if (op == dcsms_pkg::CMD_OFF && ch == 0) return 1'b0;
      // Byte-zero mode: only mask 0 moves, channels above one chip select no bit
      if (cfg_bzm) begin
         sel = (ch >= 1 && ch <= CHANS_PER_CHIP) ? 8'h01 << (ch - 1) : dcsms_pkg::MASK_NONE;
         case (op)
            dcsms_pkg::CMD_EXCL_ON: sw_mask[0] = sel;
            dcsms_pkg::CMD_ADD_ON:
               sw_mask[0] = (ch == 0) ? dcsms_pkg::MASK_NONE : (sw_mask[0] | sel);
            default:                sw_mask[0] = sw_mask[0] & ~sel;
         endcase
         return 1'b1;
      end
      // Channel 0 means none: exclusive-on clears, add-on changes nothing
      if (ch == 0) begin
         if (op == dcsms_pkg::CMD_EXCL_ON) clear_masks(n);
         return 1'b1;
      end
      chip = (ch - 1) / CHANS_PER_CHIP;
      sel  = 8'h01 << ((ch - 1) % CHANS_PER_CHIP);
      if (chip >= n) return 1'b0;
      case (op)
         dcsms_pkg::CMD_EXCL_ON: begin
            clear_masks(n);
            sw_mask[chip] = sel;
         end
         dcsms_pkg::CMD_ADD_ON: sw_mask[chip] = sw_mask[chip] | sel;
         default:               sw_mask[chip] = sw_mask[chip] & ~sel;
      endcase
      return 1'b1;
   endfunction

   // Build the words one command produces: the frame, last chip first, or one error
   function automatic void predict_frame(dcsms_pkg::req_type r);
      int n;
      n = chips_in_use();
      frame_buf.delete();
      if (!edit_masks(r, n)) begin
         frame_buf.push_back({dcsms_pkg::MASK_NONE, 1'b1, 1'b1});
         reject_count++;
      end else begin
         for (int k = 0; k < n; k++)
            frame_buf.push_back({sw_mask[n - 1 - k], (k == n - 1), 1'b0});
      end
   endfunction

   // Mostly no gap or a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic dcsms_pkg::req_type random_word();
      dcsms_pkg::req_type w;
      int                 n;
      int                 roll;
      n = chips_in_use();
      w.cmd = 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 99);
      if (roll < 75)
         w.channel = cfg_bzm ? 8'($urandom_range(0, CHANS_PER_CHIP))
                             : 8'($urandom_range(0, CHANS_PER_CHIP * n));
      else if (roll < 85)
         w.channel = 8'(cfg_limit + $urandom_range(0, 1));
      else
         w.channel = 8'($urandom_range(0, 255));
      return w;
   endfunction

   function automatic dir_row_type cmd_row(dcsms_pkg::cmd_code_type op, int ch);
      dir_row_type row;
      row = '0;
      row.word = {op, 8'(ch)};
      return row;
   endfunction

   function automatic dir_row_type one_row(dcsms_pkg::cmd_code_type op, int ch,
                                           logic [7:0] mask);
      dir_row_type row;
      row = cmd_row(op, ch);
      row.typed = 1'b1;
      row.want = {mask, 1'b1, 1'b0};
      return row;
   endfunction

   function automatic dir_row_type err_row(dcsms_pkg::cmd_code_type op, int ch);
      dir_row_type row;
      row = cmd_row(op, ch);
      row.typed = 1'b1;
      row.want = {dcsms_pkg::MASK_NONE, 1'b1, 1'b1};
      return row;
   endfunction

   function automatic dir_row_type cfg_row(dcsms_pkg::reg_index_type idx, logic [31:0] value);
      dir_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.idx = idx;
      row.value = value;
      return row;
   endfunction

   // Present one command word, hold it until taken, then record what it owes
   task automatic send_word(dcsms_pkg::req_type w, bit typed, dcsms_pkg::rsp_type want);
      int gap;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_frame(w);
      if (typed) owed_bytes.push_back(want);
      else foreach (frame_buf[i]) owed_bytes.push_back(frame_buf[i]);
      cmd_count++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every owed word, then let the block go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup phase, access phase, then back to idle on the bus
   task automatic write_reg(dcsms_pkg::reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         dcsms_pkg::REG_CHIP_COUNT:    cfg_chips = value[dcsms_pkg::CNT_W-1:0];
         dcsms_pkg::REG_CHANNEL_LIMIT: cfg_limit = value[dcsms_pkg::LIMIT_W-1:0];
         default:                      cfg_bzm   = value[0];
      endcase
      setting_count++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Pick a register setting per phase, extremes first
   task automatic new_setting(int phase);
      logic [dcsms_pkg::CNT_W-1:0]   chips;
      logic [dcsms_pkg::LIMIT_W-1:0] lim;
      logic                          bzm;
      int                            roll;
      case (phase)
         0: begin
            chips = 4'd8;
            lim   = 7'd64;
            bzm   = 1'b0;
         end
         1: begin
            chips = 4'd1;
            lim   = 7'd0;
            bzm   = 1'b0;
         end
         2: begin
            chips = 4'd8;
            lim   = 7'd127;
            bzm   = 1'b1;
         end
         default: begin
            roll  = $urandom_range(0, 9);
            chips = (roll == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
            roll  = $urandom_range(0, 3);
            case (roll)
               0:       lim = 7'd64;
               1:       lim = 7'd127;
               2:       lim = 7'(CHANS_PER_CHIP * chips);
               default: lim = 7'($urandom_range(0, 127));
            endcase
            bzm = 1'($urandom_range(0, 1));
         end
      endcase
      write_reg(dcsms_pkg::REG_CHIP_COUNT, {28'($urandom), chips});
      write_reg(dcsms_pkg::REG_CHANNEL_LIMIT, {25'($urandom), lim});
      write_reg(dcsms_pkg::REG_BYTE_ZERO_MODE, {31'($urandom), bzm});
   endtask

   // Result side: stall at random, with open stretches in between
   initial begin : ready_gen
      int hold;
      rsp_ready <= 1'b0;
      forever begin
         hold = pick_gap();
         repeat (hold) begin
            @(posedge clock);
            rsp_ready <= 1'b0;
         end
         hold = $urandom_range(1, 24);
         repeat (hold) begin
            @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each taken result word with the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         byte_count++;
         if (owed_bytes.size() == 0) begin
            $error("result word with nothing owed: frame_byte %0h last_byte %0b status %0b",
                   rsp_data.frame_byte, rsp_data.last_byte, rsp_data.status);
            fail_count++;
         end else begin
            due_word = owed_bytes.pop_front();
            if (rsp_data.frame_byte !== due_word.frame_byte) begin
               $error("frame_byte expected %0h got %0h",
                      due_word.frame_byte, rsp_data.frame_byte);
               fail_count++;
            end
            if (rsp_data.last_byte !== due_word.last_byte) begin
               $error("last_byte expected %0b got %0b",
                      due_word.last_byte, rsp_data.last_byte);
               fail_count++;
            end
            if (rsp_data.status !== due_word.status) begin
               $error("status expected %0b got %0b", due_word.status, rsp_data.status);
               fail_count++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      dir_row_type dir_rows[$];
      dir_row_type row;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      clear_masks(dcsms_pkg::MAX_CHIPS_DEF);
      cfg_chips = dcsms_pkg::CHIP_COUNT_RST;
      cfg_limit = dcsms_pkg::CHANNEL_LIMIT_RST;
      cfg_bzm   = 1'b0;

      // Single chip after reset: every frame is one word
      dir_rows.push_back(one_row(dcsms_pkg::CMD_EXCL_ON, 1, 8'h01));
      dir_rows.push_back(one_row(dcsms_pkg::CMD_ADD_ON, 8, 8'h81));
      dir_rows.push_back(one_row(dcsms_pkg::CMD_OFF, 1, 8'h80));
      dir_rows.push_back(err_row(dcsms_pkg::CMD_OFF, 0));
      dir_rows.push_back(one_row(dcsms_pkg::CMD_ADD_ON, 0, 8'h80));
      dir_rows.push_back(err_row(dcsms_pkg::CMD_ADD_ON, 9));
      dir_rows.push_back(err_row(dcsms_pkg::CMD_ADD_ON, 255));
      dir_rows.push_back(one_row(dcsms_pkg::CMD_EXCL_ON, 0, 8'h00));
      dir_rows.push_back(one_row(dcsms_pkg::CMD_ALL_OFF, 255, 8'h00));
      // Full chain, top channel and one past the limit
      dir_rows.push_back(cfg_row(dcsms_pkg::REG_CHIP_COUNT, 32'd8));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_EXCL_ON, 64));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_ADD_ON, 33));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_OFF, 64));
      dir_rows.push_back(err_row(dcsms_pkg::CMD_ADD_ON, 65));
      // Limit of zero: only channel 0 and all-off get through
      dir_rows.push_back(cfg_row(dcsms_pkg::REG_CHANNEL_LIMIT, 32'd0));
      dir_rows.push_back(err_row(dcsms_pkg::CMD_ADD_ON, 1));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_ADD_ON, 0));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_ALL_OFF, 170));
      // Byte-zero mode, including channels beyond the first chip
      dir_rows.push_back(cfg_row(dcsms_pkg::REG_CHANNEL_LIMIT, 32'd127));
      dir_rows.push_back(cfg_row(dcsms_pkg::REG_BYTE_ZERO_MODE, 32'd1));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_EXCL_ON, 3));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_ADD_ON, 200));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_OFF, 3));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_EXCL_ON, 100));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_ADD_ON, 0));
      dir_rows.push_back(err_row(dcsms_pkg::CMD_OFF, 0));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_ADD_ON, 5));
      dir_rows.push_back(err_row(dcsms_pkg::CMD_EXCL_ON, 128));
      // Chip count of zero acts as one, above eight saturates
      dir_rows.push_back(cfg_row(dcsms_pkg::REG_BYTE_ZERO_MODE, 32'd0));
      dir_rows.push_back(cfg_row(dcsms_pkg::REG_CHIP_COUNT, 32'd0));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_ADD_ON, 8));
      dir_rows.push_back(cfg_row(dcsms_pkg::REG_CHIP_COUNT, 32'd15));
      dir_rows.push_back(cmd_row(dcsms_pkg::CMD_OFF, 5));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.is_cfg) begin
            settle();
            write_reg(row.idx, row.value);
         end else begin
            send_word(row.word, row.typed, row.want);
         end
      end

      // Random phases, each under a fresh register setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         new_setting(p);
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (WORDS_PER_PHASE) send_word(random_word(), 1'b0, '0);
      end
      settle();

      $display("Sent %0d command words (%0d rejected) under %0d register writes,",
               cmd_count, reject_count, setting_count);
      $display("and checked %0d frame words against the predicted masks.", byte_count);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
